// ----- hdl/pfe_pkg.sv -----
package pfe_pkg;

  localparam logic [7:0] LetterLo = 8'd97;
  localparam logic [7:0] LetterHi = 8'd122;
  localparam logic [4:0] CodeI    = 5'd8;
  localparam logic [4:0] CodeJ    = 5'd9;

  localparam int unsigned SquareDim = 5;
  localparam int unsigned CodeW     = 5;
  localparam int unsigned RowW      = 50;
  localparam int unsigned RowLastW  = 25;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowsA   = 2'd0,
    CfgRowsB   = 2'd1,
    CfgRowLast = 2'd2
  } cfg_idx_e;

  // square[row][col] is one 5-bit letter code
  typedef logic [SquareDim-1:0][SquareDim-1:0][CodeW-1:0] square_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } pair_t;

endpackage

// ----- hdl/playfair_digraph_encrypt.sv -----
// Playfair pair encryptor: lowercase letters are encrypted two at a time with the
// 5x5 square loaded through the register port, every other byte passes through, and
// a lone non-letter between the letters of a pair comes out between the two cipher
// letters. A byte is taken every cycle while the output queue has three free places;
// it is held in the input register, and its results (none to three) are written to the
// queue when it leaves that register; the queue drains one word per cycle while the
// receiver does not stall. Sustained throughput is therefore one input byte per cycle
// when the bytes average one result each, and is limited by the single-word output
// port otherwise. Write the square only while the block is idle.
module playfair_digraph_encrypt import pfe_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [RowW-1:0]      cfg_wdata_i,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           in_byte_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_run_end_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  // configuration
  logic [RowW-1:0]     rows_a_q;
  logic [RowW-1:0]     rows_b_q;
  logic [RowLastW-1:0] row_last_q;
  square_t             square;

  // input register
  logic                in_vld_q;
  logic [7:0]          in_byte_q;

  // pairing state
  logic [CodeW-1:0]    first_q, first_d;
  logic                have_first_q, have_first_d;
  logic [7:0]          gap_q, gap_d;
  logic                have_gap_q, have_gap_d;

  // output queue
  res_t                mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;

  logic                advance;
  logic                push_room;
  logic                pop;
  logic                accept;
  logic                is_letter;
  logic [CodeW-1:0]    code;
  pair_t               pair;
  logic [1:0]          n_res;
  res_t                res0, res1, res2;

  function automatic logic [PtrW-1:0] ptr_add(logic [PtrW-1:0] p, logic [1:0] k);
    logic [PtrW+1:0] s;
    s = {2'b00, p} + {{PtrW{1'b0}}, k};
    if (s >= (PtrW+2)'(FifoDepth)) begin
      s = s - (PtrW+2)'(FifoDepth);
    end
    return s[PtrW-1:0];
  endfunction

  // -------------------------------------------------------------------------
  // register port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q   <= '0;
      rows_b_q   <= '0;
      row_last_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRowsA:   rows_a_q   <= cfg_wdata_i;
        CfgRowsB:   rows_b_q   <= cfg_wdata_i;
        CfgRowLast: row_last_q <= cfg_wdata_i[RowLastW-1:0];
        default: ;  // unused index, drop the write
      endcase
    end
  end

  assign square = {row_last_q, rows_b_q, rows_a_q};

  // -------------------------------------------------------------------------
  // input register
  assign pop       = out_valid_o && !out_stall_i;
  assign push_room = (cnt_q - CntW'(pop)) <= CntW'(FifoDepth - 3);
  assign advance   = in_vld_q && push_room;
  assign in_stall_o = in_vld_q && !push_room;
  assign accept    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  // -------------------------------------------------------------------------
  // pairing logic
  assign is_letter = (in_byte_q >= LetterLo) && (in_byte_q <= LetterHi);
  assign code      = CodeW'(in_byte_q - LetterLo);

  pfe_cipher u_cipher (
    .square_i (square),
    .first_i  (first_q),
    .second_i (code),
    .pair_o   (pair)
  );

  always_comb begin
    first_d      = first_q;
    have_first_d = have_first_q;
    gap_d        = gap_q;
    have_gap_d   = have_gap_q;
    n_res        = 2'd0;
    res0         = '{data: in_byte_q, last: 1'b1};
    res1         = '{data: pair.second, last: 1'b1};
    res2         = '{data: pair.second, last: 1'b1};
    if (!have_first_q) begin
      if (is_letter) begin
        first_d      = code;
        have_first_d = 1'b1;
      end else begin
        n_res = 2'd1;
      end
    end else if (!have_gap_q) begin
      if (!is_letter) begin
        gap_d      = in_byte_q;
        have_gap_d = 1'b1;
      end else begin
        n_res        = 2'd2;
        res0         = '{data: pair.first, last: 1'b0};
        have_first_d = 1'b0;
      end
    end else begin
      n_res = 2'd3;
      res1  = '{data: gap_q, last: 1'b0};
      if (is_letter) begin
        res0 = '{data: pair.first, last: 1'b0};
      end else begin
        // second non-letter: release everything unchanged
        res0 = '{data: LetterLo + {3'b000, first_q}, last: 1'b0};
        res2 = '{data: in_byte_q, last: 1'b1};
      end
      first_d      = '0;
      have_first_d = 1'b0;
      gap_d        = '0;
      have_gap_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= '0;
      have_first_q <= 1'b0;
      gap_q        <= '0;
      have_gap_q   <= 1'b0;
    end else if (advance) begin
      first_q      <= first_d;
      have_first_q <= have_first_d;
      gap_q        <= gap_d;
      have_gap_q   <= have_gap_d;
    end
  end

  // -------------------------------------------------------------------------
  // output queue
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (n_res >= 2'd1) begin
        mem_q[wr_ptr_q] <= res0;
      end
      if (n_res >= 2'd2) begin
        mem_q[ptr_add(wr_ptr_q, 2'd1)] <= res1;
      end
      if (n_res == 2'd3) begin
        mem_q[ptr_add(wr_ptr_q, 2'd2)] <= res2;
      end
    end
  end

  assign cnt_d = cnt_q - CntW'(pop) + (advance ? CntW'(n_res) : CntW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (advance) begin
        wr_ptr_q <= ptr_add(wr_ptr_q, n_res);
      end
      if (pop) begin
        rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o   = (cnt_q != '0);
  assign out_byte_o    = mem_q[rd_ptr_q].data;
  assign out_run_end_o = mem_q[rd_ptr_q].last;

  // -------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("output queue overfilled");

  a_gap_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_gap_q |-> have_first_q)
    else $error("gap byte held without a first letter");

  a_results_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && n_res != 2'd0) |=> out_valid_o)
    else $error("results pushed but output not valid");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && cnt_q > CntW'(FifoDepth - 3)))
    else $error("input stalled with room in the queue");

endmodule

// ----- hdl/pfe_cipher.sv -----
module pfe_cipher import pfe_pkg::*; (
  input  square_t            square_i,
  input  logic [CodeW-1:0]   first_i,
  input  logic [CodeW-1:0]   second_i,
  output pair_t              pair_o
);

  typedef struct packed {
    logic       found;
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  pos_t pos_a;
  pos_t pos_b;

  function automatic pos_t find_cell(square_t sq, logic [CodeW-1:0] code);
    pos_t             p;
    logic [CodeW-1:0] key;
    p   = '0;
    key = (code == CodeJ) ? CodeI : code;
    // scan downwards so the lowest-numbered matching cell wins
    for (int r = SquareDim - 1; r >= 0; r--) begin
      for (int k = SquareDim - 1; k >= 0; k--) begin
        if (sq[r][k] == key) begin
          p.found = 1'b1;
          p.row   = 3'(r);
          p.col   = 3'(k);
        end
      end
    end
    return p;
  endfunction

  function automatic logic [2:0] wrap_inc(logic [2:0] x);
    return (x == 3'(SquareDim - 1)) ? 3'd0 : x + 3'd1;
  endfunction

  function automatic logic [7:0] to_byte(logic [CodeW-1:0] code);
    return LetterLo + {3'b000, code};
  endfunction

  always_comb begin
    pos_a = find_cell(square_i, first_i);
    pos_b = find_cell(square_i, second_i);
    if (!pos_a.found || !pos_b.found) begin
      // pass the letters as received
      pair_o.first  = to_byte(first_i);
      pair_o.second = to_byte(second_i);
    end else if (pos_a.row == pos_b.row) begin
      pair_o.first  = to_byte(square_i[pos_a.row][wrap_inc(pos_a.col)]);
      pair_o.second = to_byte(square_i[pos_b.row][wrap_inc(pos_b.col)]);
    end else if (pos_a.col == pos_b.col) begin
      pair_o.first  = to_byte(square_i[wrap_inc(pos_a.row)][pos_a.col]);
      pair_o.second = to_byte(square_i[wrap_inc(pos_b.row)][pos_b.col]);
    end else begin
      pair_o.first  = to_byte(square_i[pos_a.row][pos_b.col]);
      pair_o.second = to_byte(square_i[pos_b.row][pos_a.col]);
    end
  end

endmodule

// ----- tb/sv/tb_playfair_digraph_encrypt.sv -----
module tb_playfair_digraph_encrypt import pfe_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned PhaseItems   = 45;
  localparam int unsigned NumPhases    = 7;

  // index with no register behind it; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef enum int {RxFree, RxLight, RxBeat, RxHeavy} rx_mode_e;
  typedef enum int {PlanAlpha, PlanKeyed, PlanRandom, PlanOnes} plan_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } cipher_word_t;

  // typed = 1: the row carries its own results, otherwise the predictor decides
  typedef struct packed {
    logic       typed;
    logic [1:0] nres;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
  } item_tag_t;

  typedef struct packed {
    logic [7:0] din;
    logic       reload;
    logic       typed;
    logic [1:0] nres;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
  } dir_row_t;

  localparam int unsigned DirLen = 25;

  // rows up to the reload run on the all-zero square left by reset: only 'a' is present
  localparam dir_row_t DirTab [DirLen] = '{
    '{8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00},
    '{8'h60, 1'b0, 1'b1, 2'd1, 8'h60, 8'h00, 8'h00},
    '{"{",   1'b0, 1'b1, 2'd1, "{",   8'h00, 8'h00},
    '{"a",   1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"a",   1'b0, 1'b1, 2'd2, "a",   "a",   8'h00},
    '{"b",   1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"z",   1'b0, 1'b1, 2'd2, "b",   "z",   8'h00},
    '{"z",   1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{" ",   1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"a",   1'b0, 1'b1, 2'd3, "z",   " ",   "a"  },
    '{"q",   1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{".",   1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b1, 2'd3, "q",   ".",   8'hFF},
    '{"a",   1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"e",   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"c",   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"r",   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"v",   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"e",   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"j",   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"i",   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"z",   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"\n",  1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"f",   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CfgRowsA;
  logic [RowW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          in_byte_i   = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic                out_run_end_o;

  playfair_digraph_encrypt dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .out_run_end_o (out_run_end_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of the square and of the pairing state
  logic [RowW-1:0]     sq_a      = '0;
  logic [RowW-1:0]     sq_b      = '0;
  logic [RowLastW-1:0] sq_last   = '0;
  logic [CodeW-1:0]    held_code = '0;
  logic                held_ok   = 1'b0;
  logic [7:0]          gap_ch    = 8'h00;
  logic                gap_ok    = 1'b0;

  cipher_word_t cipher_q[$];
  item_tag_t    item_q[$];
  int unsigned  mismatches  = 0;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left  = 0;
  int unsigned  gap_max     = 0;
  int unsigned  hold_left   = 0;
  bit           hold_req    = 1'b0;
  rx_mode_e     rx_mode     = RxFree;

  function automatic logic [CodeW-1:0] cell_at(int c);
    if (c < 10) return sq_a[5*c +: 5];
    if (c < 20) return sq_b[5*(c-10) +: 5];
    return sq_last[5*(c-20) +: 5];
  endfunction

  // lowest matching cell, 25 when the letter is absent
  function automatic int locate(logic [CodeW-1:0] code);
    if (code == CodeJ) code = CodeI;
    for (int c = 0; c < 25; c++)
      if (cell_at(c) == code) return c;
    return 25;
  endfunction

  function automatic logic [7:0] glyph(int row, int col);
    return LetterLo + 8'(cell_at(5*row + col));
  endfunction

  function automatic void encipher(input logic [CodeW-1:0] a, input logic [CodeW-1:0] b,
                                   output logic [7:0] e1, output logic [7:0] e2);
    int ca, cb, r1, k1, r2, k2;
    ca = locate(a);
    cb = locate(b);
    if (ca > 24 || cb > 24) begin
      e1 = LetterLo + 8'(a);
      e2 = LetterLo + 8'(b);
      return;
    end
    r1 = ca / 5; k1 = ca % 5;
    r2 = cb / 5; k2 = cb % 5;
    if (r1 == r2) begin
      e1 = glyph(r1, (k1 + 1) % 5);
      e2 = glyph(r2, (k2 + 1) % 5);
    end else if (k1 == k2) begin
      e1 = glyph((r1 + 1) % 5, k1);
      e2 = glyph((r2 + 1) % 5, k2);
    end else begin
      e1 = glyph(r1, k2);
      e2 = glyph(r2, k1);
    end
  endfunction

  function automatic void playfair_step(input logic [7:0] b, output int n,
                                        output logic [2:0][7:0] res);
    logic             is_letter;
    logic [CodeW-1:0] code;
    logic [7:0]       e1, e2;
    is_letter = (b >= LetterLo) && (b <= LetterHi);
    code      = CodeW'(b - LetterLo);
    n   = 0;
    res = '0;
    if (!held_ok) begin
      if (is_letter) begin
        held_code = code;
        held_ok   = 1'b1;
      end else begin
        res[0] = b;
        n      = 1;
      end
    end else if (!gap_ok) begin
      if (!is_letter) begin
        gap_ch = b;
        gap_ok = 1'b1;
      end else begin
        encipher(held_code, code, e1, e2);
        res[0]  = e1;
        res[1]  = e2;
        n       = 2;
        held_ok = 1'b0;
      end
    end else begin
      // second non-letter: the held letter goes out as received
      if (is_letter) begin
        encipher(held_code, code, e1, e2);
      end else begin
        e1 = LetterLo + 8'(held_code);
        e2 = b;
      end
      res[0]    = e1;
      res[1]    = gap_ch;
      res[2]    = e2;
      n         = 3;
      held_ok   = 1'b0;
      gap_ok    = 1'b0;
      held_code = '0;
      gap_ch    = 8'h00;
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    cipher_word_t     want;
    item_tag_t        tag;
    int               n;
    logic [2:0][7:0]  res;
    if (out_valid_o && !out_stall_i) begin
      if (cipher_q.size() == 0) begin
        note_mismatch($sformatf("word %h/%b with nothing pending", out_byte_o, out_run_end_o));
      end else begin
        want = cipher_q.pop_front();
        if (out_byte_o !== want.ch || out_run_end_o !== want.fin)
          note_mismatch($sformatf("byte/run_end expected %h/%b, got %h/%b",
                                  want.ch, want.fin, out_byte_o, out_run_end_o));
      end
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRowsA:   sq_a    = cfg_wdata_i;
        CfgRowsB:   sq_b    = cfg_wdata_i;
        CfgRowLast: sq_last = cfg_wdata_i[RowLastW-1:0];
        default:    ;
      endcase
    end
    if (in_valid_i && !in_stall_o) begin
      tag = (item_q.size() != 0) ? item_q.pop_front() : '0;
      playfair_step(in_byte_i, n, res);
      if (tag.typed) begin
        n   = tag.nres;
        res = {tag.r2, tag.r1, tag.r0};
      end
      for (int k = 0; k < n; k++) cipher_q.push_back('{ch: res[k], fin: (k == n - 1)});
    end
  end

  always @(posedge clk_i) begin : rx_pacing
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (rx_mode)
        RxLight: out_stall_i <= ($urandom_range(99) < 30);
        RxBeat:  out_stall_i <= ((cycle_count % 7) < 3);
        RxHeavy: out_stall_i <= ($urandom_range(99) < 75);
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input item_tag_t tag);
    if (gap_max > 0 && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(posedge clk_i);
      burst_left = $urandom_range(12, 1);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    item_q.push_back(tag);
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left > 0) burst_left--;
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_plan(input plan_e kind);
    logic [CodeW-1:0]    pool [25];
    logic [CodeW-1:0]    t;
    int                  k, j;
    logic [RowW-1:0]     wa, wb;
    logic [RowLastW-1:0] wl;
    k = 0;
    for (int c = 0; c < 26; c++)
      if (CodeW'(c) != CodeJ) begin
        pool[k] = CodeW'(c);
        k++;
      end
    case (kind)
      PlanKeyed: begin
        for (int i = 24; i > 0; i--) begin
          j       = $urandom_range(i);
          t       = pool[i];
          pool[i] = pool[j];
          pool[j] = t;
        end
        // now and then key on 'j' instead of 'i', leaving both unmatched
        if ($urandom_range(3) == 0)
          foreach (pool[i]) if (pool[i] == CodeI) pool[i] = CodeJ;
      end
      PlanRandom: foreach (pool[i]) pool[i] = CodeW'($urandom_range(31));
      PlanOnes:   foreach (pool[i]) pool[i] = '1;
      default:    ;
    endcase
    for (int i = 0; i < 10; i++) begin
      wa[5*i +: 5] = pool[i];
      wb[5*i +: 5] = pool[10 + i];
    end
    for (int i = 0; i < 5; i++) wl[5*i +: 5] = pool[20 + i];
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgRowsA;
    cfg_wdata_i <= wa;
    @(posedge clk_i);
    cfg_idx_i   <= CfgRowsB;
    cfg_wdata_i <= wb;
    @(posedge clk_i);
    // upper bits are junk and must be masked off
    cfg_idx_i   <= CfgRowLast;
    cfg_wdata_i <= {25'($urandom), wl};
    @(posedge clk_i);
    if ($urandom_range(1) == 1) begin
      cfg_idx_i   <= CfgSpare;
      cfg_wdata_i <= RowW'({$urandom, $urandom});
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 65) return LetterLo + 8'($urandom_range(25));
    b = 8'($urandom_range(255));
    if (r < 85)
      while (b >= LetterLo && b <= LetterHi) b = 8'($urandom_range(255));
    return b;
  endfunction

  initial begin : stimulus
    plan_e kind;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rx_mode = RxLight;
    gap_max = 3;
    foreach (DirTab[i]) begin
      if (DirTab[i].reload) begin
        settle();
        load_plan(PlanAlpha);
      end
      send_byte(DirTab[i].din, '{typed: DirTab[i].typed, nres: DirTab[i].nres,
                                 r0: DirTab[i].r0, r1: DirTab[i].r1, r2: DirTab[i].r2});
    end

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      kind = PlanKeyed;
      case (p)
        0: begin rx_mode = RxLight; gap_max = 4; end
        1: begin rx_mode = RxFree;  gap_max = 0; end
        2: begin rx_mode = RxFree;  gap_max = 0; end
        3: begin rx_mode = RxHeavy; gap_max = 6; kind = PlanRandom; end
        4: begin rx_mode = RxBeat;  gap_max = 2; kind = PlanOnes; end
        5: begin rx_mode = RxLight; gap_max = 3; kind = PlanRandom; end
        default: begin rx_mode = RxBeat; gap_max = 1; end
      endcase
      load_plan(kind);
      // long receiver hold-off while the sender keeps pushing
      if (p == 2) hold_req = 1'b1;
      repeat (PhaseItems) send_byte(pick_byte(), '0);
    end

    settle();
    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
